FILE: rtl/deqs_pkg.sv
// shared types, constants and ring index helper for the double-ended queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deqs_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = IDX_W + 1;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SEARCH,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // ring position of base + off, with base < DEPTH and off <= DEPTH
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/deqs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/deqs_front.sv
// front end: takes command transfers, decodes the kind and queues them
// depends on deqs_pkg
`timescale 1ns / 1ps
`default_nettype none

module deqs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [deqs_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [deqs_pkg::DATA_W-1:0]   i_value,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output deqs_pkg::t_cmd                     o_cmd
);

    deqs_pkg::t_cmd                       r_slot [deqs_pkg::FQ_DEPTH];
    logic [deqs_pkg::FQ_PTR_W-1:0]        r_wr;
    logic [deqs_pkg::FQ_PTR_W-1:0]        r_rd;
    logic [deqs_pkg::FQ_CNT_W-1:0]        r_cnt;
    logic [deqs_pkg::FQ_PTR_W-1:0]        n_wr;
    logic [deqs_pkg::FQ_PTR_W-1:0]        n_rd;
    logic [deqs_pkg::FQ_CNT_W-1:0]        n_cnt;
    deqs_pkg::t_cmd                       dec_cmd;
    logic                                 push;
    logic                                 pop;

    always_comb begin
        dec_cmd.value = i_value;
        unique case (i_kind)
            deqs_pkg::KIND_PUSH_BACK:  dec_cmd.op = deqs_pkg::OP_PUSH_BACK;
            deqs_pkg::KIND_PUSH_FRONT: dec_cmd.op = deqs_pkg::OP_PUSH_FRONT;
            deqs_pkg::KIND_POP_FRONT:  dec_cmd.op = deqs_pkg::OP_POP_FRONT;
            deqs_pkg::KIND_POP_BACK:   dec_cmd.op = deqs_pkg::OP_POP_BACK;
            deqs_pkg::KIND_SEARCH:     dec_cmd.op = deqs_pkg::OP_SEARCH;
            deqs_pkg::KIND_CLEAR:      dec_cmd.op = deqs_pkg::OP_CLEAR;
            default:                   dec_cmd.op = deqs_pkg::OP_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != deqs_pkg::FQ_CNT_W'(deqs_pkg::FQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_slot[r_rd];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == deqs_pkg::FQ_PTR_W'(deqs_pkg::FQ_DEPTH - 1)) ? '0
                   : r_wr + deqs_pkg::FQ_PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == deqs_pkg::FQ_PTR_W'(deqs_pkg::FQ_DEPTH - 1)) ? '0
                   : r_rd + deqs_pkg::FQ_PTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + deqs_pkg::FQ_CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - deqs_pkg::FQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_slot[r_wr] <= dec_cmd;
        end
    end

    // queue never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= deqs_pkg::FQ_CNT_W'(deqs_pkg::FQ_DEPTH))
        else $error("front queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/deqs_back.sv
// back end: executes queued commands on the ring and drives the result register
// depends on deqs_pkg and deqs_ram
`timescale 1ns / 1ps
`default_nettype none

module deqs_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_valid,
    output logic                                 o_cmd_ready,
    input  deqs_pkg::t_cmd                       i_cmd,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [deqs_pkg::DATA_W-1:0]          o_popped,
    output logic [deqs_pkg::CNT_W-1:0]           o_match,
    output logic [deqs_pkg::CNT_W-1:0]           o_count,
    output deqs_pkg::t_status                    o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SRCH,
        S_RES
    } t_state;

    t_state                             r_state;
    logic [deqs_pkg::IDX_W-1:0]         r_head;
    logic [deqs_pkg::CNT_W-1:0]         r_occ;
    logic [deqs_pkg::DATA_W-1:0]        r_value;
    logic [deqs_pkg::CNT_W-1:0]         r_off;
    logic [deqs_pkg::CNT_W-1:0]         r_pend;
    logic [deqs_pkg::CNT_W-1:0]         r_match;
    logic [deqs_pkg::DATA_W-1:0]        r_popped;
    deqs_pkg::t_status                  r_status;
    logic                               r_o_valid;
    logic [deqs_pkg::DATA_W-1:0]        r_o_popped;
    logic [deqs_pkg::CNT_W-1:0]         r_o_match;
    logic [deqs_pkg::CNT_W-1:0]         r_o_count;
    deqs_pkg::t_status                  r_o_status;

    logic                               is_full;
    logic                               is_empty;
    logic [deqs_pkg::IDX_W-1:0]         head_prev;
    logic [deqs_pkg::IDX_W-1:0]         head_next;
    logic                               take;
    logic                               out_free;
    logic                               ram_we;
    logic [deqs_pkg::IDX_W-1:0]         ram_waddr;
    logic                               ram_re;
    logic [deqs_pkg::IDX_W-1:0]         ram_raddr;
    logic [deqs_pkg::DATA_W-1:0]        ram_rdata;

    assign is_full     = (r_occ == deqs_pkg::CNT_W'(deqs_pkg::DEPTH));
    assign is_empty    = (r_occ == '0);
    assign head_prev   = (r_head == '0) ? deqs_pkg::IDX_W'(deqs_pkg::DEPTH - 1)
                         : r_head - deqs_pkg::IDX_W'(1);
    assign head_next   = (r_head == deqs_pkg::IDX_W'(deqs_pkg::DEPTH - 1)) ? '0
                         : r_head + deqs_pkg::IDX_W'(1);
    assign o_cmd_ready = (r_state == S_IDLE);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_o_valid || i_ready;

    // ring port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (take) begin
            unique case (i_cmd.op)
                deqs_pkg::OP_PUSH_BACK: begin
                    ram_we    = !is_full;
                    ram_waddr = deqs_pkg::ring_pos(r_head, r_occ);
                end
                deqs_pkg::OP_PUSH_FRONT: begin
                    ram_we    = !is_full;
                    ram_waddr = head_prev;
                end
                deqs_pkg::OP_POP_FRONT: begin
                    ram_re    = !is_empty;
                    ram_raddr = r_head;
                end
                deqs_pkg::OP_POP_BACK: begin
                    ram_re    = !is_empty;
                    ram_raddr = deqs_pkg::ring_pos(r_head, r_occ - deqs_pkg::CNT_W'(1));
                end
                deqs_pkg::OP_SEARCH: begin
                    ram_re    = !is_empty;
                    ram_raddr = r_head;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_SRCH && r_off < r_occ) begin
            ram_re    = 1'b1;
            ram_raddr = deqs_pkg::ring_pos(r_head, r_off);
        end
    end

    deqs_ram #(
        .WIDTH (deqs_pkg::DATA_W),
        .DEPTH (deqs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_RES && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_popped <= '0;
                        r_match  <= '0;
                        r_value  <= i_cmd.value;
                        unique case (i_cmd.op)
                            deqs_pkg::OP_PUSH_BACK: begin
                                r_state <= S_RES;
                                if (is_full) begin
                                    r_status <= deqs_pkg::ST_FULL;
                                end else begin
                                    r_status <= deqs_pkg::ST_OK;
                                    r_occ    <= r_occ + deqs_pkg::CNT_W'(1);
                                end
                            end
                            deqs_pkg::OP_PUSH_FRONT: begin
                                r_state <= S_RES;
                                if (is_full) begin
                                    r_status <= deqs_pkg::ST_FULL;
                                end else begin
                                    r_status <= deqs_pkg::ST_OK;
                                    r_head   <= head_prev;
                                    r_occ    <= r_occ + deqs_pkg::CNT_W'(1);
                                end
                            end
                            deqs_pkg::OP_POP_FRONT: begin
                                if (is_empty) begin
                                    r_status <= deqs_pkg::ST_EMPTY;
                                    r_state  <= S_RES;
                                end else begin
                                    r_status <= deqs_pkg::ST_OK;
                                    r_head   <= head_next;
                                    r_occ    <= r_occ - deqs_pkg::CNT_W'(1);
                                    r_state  <= S_POP;
                                end
                            end
                            deqs_pkg::OP_POP_BACK: begin
                                if (is_empty) begin
                                    r_status <= deqs_pkg::ST_EMPTY;
                                    r_state  <= S_RES;
                                end else begin
                                    r_status <= deqs_pkg::ST_OK;
                                    r_occ    <= r_occ - deqs_pkg::CNT_W'(1);
                                    r_state  <= S_POP;
                                end
                            end
                            deqs_pkg::OP_SEARCH: begin
                                if (is_empty) begin
                                    r_status <= deqs_pkg::ST_EMPTY;
                                    r_state  <= S_RES;
                                end else begin
                                    r_status <= deqs_pkg::ST_OK;
                                    r_off    <= deqs_pkg::CNT_W'(1);
                                    r_pend   <= r_occ;
                                    r_state  <= S_SRCH;
                                end
                            end
                            deqs_pkg::OP_CLEAR: begin
                                r_status <= deqs_pkg::ST_OK;
                                r_state  <= S_RES;
                                r_head   <= '0;
                                r_occ    <= '0;
                            end
                            default: begin
                                r_status <= deqs_pkg::ST_OK;
                                r_state  <= S_RES;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_popped <= ram_rdata;
                    r_state  <= S_RES;
                end
                S_SRCH: begin
                    if (ram_rdata == r_value) begin
                        r_match <= r_match + deqs_pkg::CNT_W'(1);
                    end
                    r_pend <= r_pend - deqs_pkg::CNT_W'(1);
                    if (r_off < r_occ) begin
                        r_off <= r_off + deqs_pkg::CNT_W'(1);
                    end
                    if (r_pend == deqs_pkg::CNT_W'(1)) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_o_popped <= r_popped;
                        r_o_match  <= r_match;
                        r_o_count  <= r_occ;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid  = r_o_valid;
    assign o_popped = r_o_popped;
    assign o_match  = r_o_match;
    assign o_count  = r_o_count;
    assign o_status = r_o_status;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= deqs_pkg::CNT_W'(deqs_pkg::DEPTH))
        else $error("occupancy above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= deqs_pkg::IDX_W'(deqs_pkg::DEPTH - 1))
        else $error("head index outside ring");

    a_srch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_occ != '0 && r_pend != '0 && r_pend <= r_occ))
        else $error("search walk out of step with occupancy");

    a_srch_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_match <= r_occ - r_pend))
        else $error("match count ahead of compares");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE && !is_full))
        else $error("ring written outside a push");

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_with_search.sv
// top level of the double-ended queue with search: front decode queue and back executor
// depends on deqs_pkg, deqs_front, deqs_back (and deqs_ram through deqs_back)
//
//   channel   direction  handshake            payload
//   command   in         i_valid / o_ready    i_kind, i_value
//   result    out        o_valid / i_ready    o_popped_value, o_match_count,
//                                             o_element_count, o_status
//
// push, clear, no-op and refused commands: from taking the command to the result state, then the result register
// pops: a read state is added for the registered read of the entry ram
// search: one entry compared per cycle over the single ram read port, then the result state
// a two-entry command queue keeps taking transfers, until it is full, while the executor or result side stalls
// reset (synchronous, active low) empties the queue and clears head and occupancy;
// entry contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_with_search (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic        [deqs_pkg::KIND_W-1:0]  i_kind,
    input  wire logic signed [deqs_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed      [deqs_pkg::DATA_W-1:0]  o_popped_value,
    output logic             [deqs_pkg::CNT_W-1:0]   o_match_count,
    output logic             [deqs_pkg::CNT_W-1:0]   o_element_count,
    output logic             [deqs_pkg::STATUS_W-1:0] o_status
);

    logic                              cmd_valid;
    logic                              cmd_ready;
    deqs_pkg::t_cmd                    cmd;
    logic [deqs_pkg::DATA_W-1:0]       popped;
    deqs_pkg::t_status                 status;

    deqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    deqs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_popped    (popped),
        .o_match     (o_match_count),
        .o_count     (o_element_count),
        .o_status    (status)
    );

    assign o_popped_value = $signed(popped);
    assign o_status       = status;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for double_ended_queue_with_search: queued command driver,
// result monitor and a cycle-free model of the ring that predicts every result
// depends on deqs_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;
    import deqs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int IDLE_PCT = 37;
    localparam int QUIET_LO = 3000;
    localparam int QUIET_HI = 6000;
    localparam int RANDOM_CMDS = 1450;
    localparam int PHASE_LEN = 48;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } t_deque_cmd;

    typedef struct {
        logic signed [DATA_W-1:0] popped;
        logic [CNT_W-1:0]         hits;
        logic [CNT_W-1:0]         held;
        t_status                  status;
    } t_deque_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [KIND_W-1:0]           i_kind = '0;
    logic signed [DATA_W-1:0]    i_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic signed [DATA_W-1:0]    o_popped_value;
    logic [CNT_W-1:0]            o_match_count;
    logic [CNT_W-1:0]            o_element_count;
    logic [STATUS_W-1:0]         o_status;

    double_ended_queue_with_search u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_popped_value  (o_popped_value),
        .o_match_count   (o_match_count),
        .o_element_count (o_element_count),
        .o_status        (o_status)
    );

    // model state of the ring
    logic signed [DATA_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]         front_pos = '0;
    logic [CNT_W-1:0]         held_count = '0;

    t_deque_cmd   cmds_pending [$];
    t_deque_reply replies_due [$];

    int cyc = 0;
    int n_taken = 0;
    int n_loaded = 0;
    int n_results = 0;
    int n_full = 0;
    int n_empty = 0;
    int max_hits = 0;
    int fail_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic apply_deque_cmd(input logic [KIND_W-1:0] kind,
                                   input logic signed [DATA_W-1:0] value);
        t_deque_reply r;
        logic [IDX_W-1:0] pos;
        r.popped = '0;
        r.hits = '0;
        r.status = ST_OK;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (held_count >= CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                end else if (kind == KIND_PUSH_BACK) begin
                    pos = front_pos + held_count[IDX_W-1:0];
                    ring_words[pos] = value;
                    held_count = held_count + 1'b1;
                end else begin
                    front_pos = front_pos - 1'b1;
                    ring_words[front_pos] = value;
                    held_count = held_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (held_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = ring_words[front_pos];
                    front_pos = front_pos + 1'b1;
                    held_count = held_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (held_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held_count = held_count - 1'b1;
                    pos = front_pos + held_count[IDX_W-1:0];
                    r.popped = ring_words[pos];
                end
            end
            KIND_SEARCH: begin
                if (held_count == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < int'(held_count); k++) begin
                        pos = front_pos + IDX_W'(k);
                        if (ring_words[pos] === value) begin
                            r.hits = r.hits + 1'b1;
                        end
                    end
                end
            end
            KIND_CLEAR: begin
                front_pos = '0;
                held_count = '0;
            end
            default: begin
            end
        endcase
        r.held = held_count;
        replies_due.push_back(r);
    endtask

    function automatic bit skip_cycle();
        if (cyc >= QUIET_LO && cyc < QUIET_HI) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic queue_cmd(input logic [KIND_W-1:0] kind,
                             input logic signed [DATA_W-1:0] value);
        t_deque_cmd c;
        c.kind = kind;
        c.value = value;
        cmds_pending.push_back(c);
    endtask

    task automatic check_field(input string what, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // command side: transfer taken at the rising edge, next command presented at the falling one
    always @(posedge i_clk) begin
        cyc = cyc + 1;
        if (i_rst_n && i_valid && o_ready) begin
            apply_deque_cmd(i_kind, i_value);
            n_taken = n_taken + 1;
        end
    end

    always @(negedge i_clk) begin : drive_cmds
        t_deque_cmd c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || n_taken == n_loaded) begin
            if (cmds_pending.size() != 0 && !skip_cycle()) begin
                c = cmds_pending.pop_front();
                i_valid <= 1'b1;
                i_kind <= c.kind;
                i_value <= c.value;
                n_loaded = n_loaded + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= i_rst_n && !skip_cycle();
    end

    // result side
    always @(posedge i_clk) begin : watch_results
        t_deque_reply r;
        if (i_rst_n && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t ns: result with nothing outstanding, expected none got count %0d",
                         $time, o_element_count);
                fail_count++;
            end else begin
                r = replies_due.pop_front();
                check_field("popped_value", r.popped, o_popped_value);
                check_field("match_count", r.hits, o_match_count);
                check_field("element_count", r.held, o_element_count);
                check_field("status", r.status, o_status);
                n_results++;
                if (r.status == ST_FULL) n_full++;
                if (r.status == ST_EMPTY) n_empty++;
                if (int'(r.hits) > max_hits) max_hits = int'(r.hits);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", replies_due.size());
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic signed [DATA_W-1:0] pool [4];
        logic [KIND_W-1:0] kind;
        logic signed [DATA_W-1:0] value;
        int mode;
        int pick;
        bit same_val;

        // directed: empty cases, extremes, spare codes, front push into empty list
        queue_cmd(KIND_CLEAR, 0);
        queue_cmd(KIND_POP_FRONT, 0);
        queue_cmd(KIND_POP_BACK, 0);
        queue_cmd(KIND_SEARCH, 0);
        queue_cmd(KIND_SPARE_LO, 32'h7fffffff);
        queue_cmd(KIND_SPARE_HI, 32'h80000000);
        queue_cmd(KIND_PUSH_FRONT, 32'h12345678);
        queue_cmd(KIND_POP_BACK, 0);
        queue_cmd(KIND_PUSH_BACK, 32'h80000000);
        queue_cmd(KIND_PUSH_FRONT, 32'h7fffffff);
        queue_cmd(KIND_PUSH_BACK, -1);
        queue_cmd(KIND_PUSH_FRONT, 0);
        queue_cmd(KIND_PUSH_BACK, -1);
        queue_cmd(KIND_SEARCH, -1);
        queue_cmd(KIND_SEARCH, 32'h80000000);
        queue_cmd(KIND_SEARCH, 32'h00000001);
        queue_cmd(KIND_SPARE_LO, 0);
        queue_cmd(KIND_POP_FRONT, 0);
        queue_cmd(KIND_POP_BACK, 0);
        queue_cmd(KIND_POP_FRONT, 0);
        queue_cmd(KIND_CLEAR, 0);
        queue_cmd(KIND_CLEAR, 0);
        queue_cmd(KIND_PUSH_FRONT, 32'h5a5aa5a5);
        queue_cmd(KIND_POP_FRONT, 0);

        same_val = 1'b0;
        mode = 0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % PHASE_LEN == 0) begin
                mode = $urandom_range(3);
                same_val = $urandom_range(3) == 0;
                foreach (pool[j]) begin
                    pool[j] = ($urandom_range(1) == 0) ? DATA_W'($urandom_range(3)) : $urandom;
                end
            end
            pick = $urandom_range(99);
            case (mode)
                0: kind = (pick < 70) ? KIND_PUSH_BACK : (pick < 85) ? KIND_SEARCH :
                          (pick < 95) ? KIND_POP_FRONT : KIND_SPARE_LO;
                1: kind = (pick < 70) ? KIND_POP_FRONT : (pick < 85) ? KIND_SEARCH :
                          (pick < 95) ? KIND_PUSH_BACK : KIND_SPARE_LO;
                2: kind = (pick < 40) ? KIND_PUSH_BACK : (pick < 80) ? KIND_POP_FRONT :
                          (pick < 95) ? KIND_SEARCH : KIND_SPARE_LO;
                default: kind = (pick < 45) ? KIND_SEARCH : (pick < 70) ? KIND_PUSH_BACK :
                                (pick < 95) ? KIND_POP_FRONT : KIND_SPARE_LO;
            endcase
            // pick the end of the queue, or one of the rarely used codes
            if (kind == KIND_PUSH_BACK && $urandom_range(1) == 0) kind = KIND_PUSH_FRONT;
            if (kind == KIND_POP_FRONT && $urandom_range(1) == 0) kind = KIND_POP_BACK;
            if (kind == KIND_SPARE_LO) begin
                case ($urandom_range(2))
                    0: kind = KIND_CLEAR;
                    1: kind = KIND_SPARE_LO;
                    default: kind = KIND_SPARE_HI;
                endcase
            end
            pick = $urandom_range(9);
            if (same_val && pick < 8) value = pool[0];
            else if (pick < 5) value = pool[$urandom_range(3)];
            else if (pick < 8) value = $urandom;
            else if (pick == 8) value = 32'h80000000;
            else value = 32'h7fffffff;
            queue_cmd(kind, value);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmds_pending.size() != 0 || i_valid) @(negedge i_clk);
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (2 * DEPTH + 16) @(negedge i_clk);

        $display("%0d commands checked: %0d refused pushes, %0d empty reports, largest match %0d",
                 n_results, n_full, n_empty, max_hits);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
